// File: hw/rtl/ptpd_pkg.sv
// Shared types and constants for the peak-to-peak drop detector.
// No dependencies; every other file of the block imports this package.
package ptpd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DiffW   = SampleW + 1;
  localparam int unsigned CountW  = 2;

  localparam logic [SampleW-1:0] ThresholdReset = SampleW'(300);
  localparam logic [CountW-1:0]  ConfirmReset   = CountW'(2);
  localparam logic [SampleW-1:0] TrackMinReset  = '1;
  localparam logic [SampleW-1:0] TrackMaxReset  = '0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_DIFF_THRESHOLD  = 1'b0,
    REG_CONFIRM_WINDOWS = 1'b1
  } cfg_reg_t;

  // Item operation codes.
  typedef enum logic [0:0] {
    OP_SAMPLE   = 1'b0,
    OP_EVALUATE = 1'b1
  } op_t;

  // One item leaving the input register into the processing logic.
  typedef struct packed {
    logic               fire;
    op_t                op;
    logic [SampleW-1:0] sample;
  } step_t;

  // Current tracker contents.
  typedef struct packed {
    logic [SampleW-1:0] smallest;
    logic [SampleW-1:0] second_smallest;
    logic [SampleW-1:0] largest;
    logic [SampleW-1:0] second_largest;
  } track_t;

endpackage

// File: hw/rtl/ptpd_track.sv
// Two-smallest / two-largest sample trackers of the current window.
// Depends on ptpd_pkg.
module ptpd_track import ptpd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  step_t  step,
  output track_t trk
);

  track_t trk_r, trk_nxt;

  always_comb begin
    trk_nxt = trk_r;
    if (step.fire) begin
      if (step.op == OP_EVALUATE) begin
        trk_nxt.smallest        = TrackMinReset;
        trk_nxt.second_smallest = TrackMinReset;
        trk_nxt.largest         = TrackMaxReset;
        trk_nxt.second_largest  = TrackMaxReset;
      end else begin
        // Strict compares: a tie never displaces a tracked value.
        if (step.sample < trk_r.second_smallest) begin
          if (step.sample < trk_r.smallest) begin
            trk_nxt.second_smallest = trk_r.smallest;
            trk_nxt.smallest        = step.sample;
          end else begin
            trk_nxt.second_smallest = step.sample;
          end
        end
        if (step.sample > trk_r.second_largest) begin
          if (step.sample > trk_r.largest) begin
            trk_nxt.second_largest = trk_r.largest;
            trk_nxt.largest        = step.sample;
          end else begin
            trk_nxt.second_largest = step.sample;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r.smallest        <= TrackMinReset;
      trk_r.second_smallest <= TrackMinReset;
      trk_r.largest         <= TrackMaxReset;
      trk_r.second_largest  <= TrackMaxReset;
    end else begin
      trk_r <= trk_nxt;
    end
  end

  assign trk = trk_r;

endmodule

// File: hw/rtl/ptpd_eval.sv
// Window evaluation: pair averages, difference, confirmation count and trigger.
// Depends on ptpd_pkg.
module ptpd_eval import ptpd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  step_t                    step,
  input  track_t                   trk,
  input  logic [SampleW-1:0]       diff_threshold,
  input  logic [CountW-1:0]        confirm_windows,
  output logic                     trigger_next,
  output logic signed [DiffW-1:0]  difference,
  output logic                     trigger
);

  logic [CountW-1:0]  count_r, count_nxt;
  logic               trig_r, trig_nxt;
  logic [DiffW-1:0]   sum_min, sum_max;
  logic [SampleW-1:0] avg_min, avg_max;
  logic [CountW-1:0]  need;
  logic [CountW:0]    count_inc;
  logic               below;

  always_comb begin
    sum_min    = {1'b0, trk.smallest} + {1'b0, trk.second_smallest};
    sum_max    = {1'b0, trk.largest} + {1'b0, trk.second_largest};
    avg_min    = sum_min[DiffW-1:1];
    avg_max    = sum_max[DiffW-1:1];
    difference = $signed({1'b0, avg_max}) - $signed({1'b0, avg_min});
    below      = difference < $signed({1'b0, diff_threshold});
    need       = (confirm_windows == '0) ? CountW'(1) : confirm_windows;
    count_inc  = {1'b0, count_r} + (CountW+1)'(1);

    count_nxt = count_r;
    trig_nxt  = trig_r;
    if (step.fire && step.op == OP_EVALUATE) begin
      if (below) begin
        if (count_inc >= {1'b0, need}) begin
          trig_nxt  = 1'b1;
          count_nxt = need - CountW'(1);
        end else begin
          count_nxt = count_inc[CountW-1:0];
        end
      end else begin
        trig_nxt  = 1'b0;
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      trig_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      trig_r  <= trig_nxt;
    end
  end

  assign trigger_next = trig_nxt;
  assign trigger      = trig_r;

endmodule

// File: hw/rtl/peak_to_peak_drop_detector.sv
// Peak-to-peak drop detector: top level with input and result registers.
// Depends on ptpd_pkg, ptpd_track and ptpd_eval.

// Each transfer is either a sample, which updates the two smallest and two
// largest values of the window, or a window end, which compares the averaged
// peak-to-peak difference with diff_threshold and updates the trigger after
// confirm_windows consecutive low windows. Every item gives exactly one result.
// An item passes through the input register, then the result register. One item
// can be taken every cycle, except while a held result (out_valid high, out_ready
// low) stalls the input register. Configuration writes are always taken and
// should be made only while no item is in flight.
module peak_to_peak_drop_detector import ptpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_opcode,
  input  logic [SampleW-1:0]      in_sample,
  input  logic                    in_pwm_level,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_trigger,
  output logic                    out_pin_level,
  output logic signed [DiffW-1:0] out_difference,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [SampleW-1:0]      cfg_data
);

  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [SampleW-1:0] s1_sample_r;
  logic               s1_pwm_r;
  logic               s1_adv;

  logic                    out_valid_r;
  logic                    out_eval_r;
  logic                    out_trigger_r;
  logic                    out_pin_r;
  logic signed [DiffW-1:0] out_diff_r;

  logic [SampleW-1:0] thr_r;
  logic [CountW-1:0]  confirm_r;

  step_t                   step;
  track_t                  trk;
  logic                    trig_next;
  logic                    trig_cur;
  logic signed [DiffW-1:0] diff;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= ThresholdReset;
      confirm_r <= ConfirmReset;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIFF_THRESHOLD:  thr_r     <= cfg_data;
        REG_CONFIRM_WINDOWS: confirm_r <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r     <= op_t'(in_opcode);
      s1_sample_r <= in_sample;
      s1_pwm_r    <= in_pwm_level;
    end
  end

  assign step = '{fire: s1_adv, op: s1_op_r, sample: s1_sample_r};

  ptpd_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .trk   (trk)
  );

  ptpd_eval u_eval (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .trk             (trk),
    .diff_threshold  (thr_r),
    .confirm_windows (confirm_r),
    .trigger_next    (trig_next),
    .difference      (diff),
    .trigger         (trig_cur)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_eval_r    <= (s1_op_r == OP_EVALUATE);
      out_trigger_r <= trig_next;
      out_pin_r     <= !trig_next && !s1_pwm_r;
      out_diff_r    <= (s1_op_r == OP_EVALUATE) ? diff : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_trigger    = out_trigger_r;
  assign out_pin_level  = out_pin_r;
  assign out_difference = out_diff_r;

  // The trackers stay ordered within a window.
  assert property (@(posedge clk) disable iff (!rst_n)
    trk.smallest <= trk.second_smallest && trk.largest >= trk.second_largest)
    else $error("tracker pair out of order");

  // A sample transfer never changes the trigger.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_op_r == OP_SAMPLE |=> $stable(trig_cur))
    else $error("trigger changed on a sample");

  // Sample results carry a zero difference.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_eval_r |-> out_diff_r == '0)
    else $error("nonzero difference on a sample result");

  // A triggered result always drives the pin low.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && trig_next |=> !out_pin_r)
    else $error("pin high while triggered");

endmodule
